/* src/tms_pkg.sv */
// shared types and constants for the turing machine step engine
// no dependencies; imported by every module of the block except tms_ram
package tms_pkg;

	localparam int MAX_STATES  = 64;
	localparam int MAX_SYMBOLS = 16;
	localparam int TAPE_CELLS  = 1024;

	localparam int STATE_W   = $clog2(MAX_STATES);
	localparam int SYM_W     = $clog2(MAX_SYMBOLS);
	localparam int HEAD_W    = $clog2(TAPE_CELLS);
	localparam int ACT_W     = 3;
	localparam int ST_W      = 3;
	localparam int MOVE_W    = 2;
	localparam int NSTATES_W = 7;
	localparam int NSYMS_W   = 5;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	localparam int RULE_ADDR_W = STATE_W + SYM_W;
	localparam int RULE_DEPTH  = MAX_STATES * MAX_SYMBOLS;
	localparam int RULE_W      = 1 + SYM_W + MOVE_W + 1 + STATE_W;

	localparam logic [NSTATES_W-1:0] NUM_STATES_RST  = NSTATES_W'(64);
	localparam logic [NSYMS_W-1:0]   NUM_SYMBOLS_RST = NSYMS_W'(16);

	// action codes
	localparam logic [ACT_W-1:0] ACT_LOAD_RULE = 3'd0;
	localparam logic [ACT_W-1:0] ACT_LOAD_TAPE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_START     = 3'd2;
	localparam logic [ACT_W-1:0] ACT_STEP      = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ      = 3'd4;

	// head moves
	localparam logic [MOVE_W-1:0] MV_STAY  = 2'd0;
	localparam logic [MOVE_W-1:0] MV_LEFT  = 2'd1;
	localparam logic [MOVE_W-1:0] MV_RIGHT = 2'd2;
	localparam logic [MOVE_W-1:0] MV_HALT  = 2'd3;

	// result status
	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_HALTED    = 3'd1;
	localparam logic [ST_W-1:0] ST_BAD_STATE = 3'd2;
	localparam logic [ST_W-1:0] ST_BAD_HEAD  = 3'd3;
	localparam logic [ST_W-1:0] ST_BAD_WRITE = 3'd4;
	localparam logic [ST_W-1:0] ST_BAD_NEXT  = 3'd5;
	localparam logic [ST_W-1:0] ST_EDGE      = 3'd6;
	localparam logic [ST_W-1:0] ST_STOPPED   = 3'd7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_SYMBOLS = 1'd1;

	typedef struct packed {
		logic               wflag;
		logic [SYM_W-1:0]   wsym;
		logic [MOVE_W-1:0]  mv;
		logic               nflag;
		logic [STATE_W-1:0] nstate;
	} rule_t;

	// context carried by one transaction from cell to cell
	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic               fwd;
		logic [SYM_W-1:0]   symbol;
		logic [SYM_W-1:0]   sym;
		logic [ST_W-1:0]    status;
		logic [HEAD_W-1:0]  head;
		logic [STATE_W-1:0] cstate;
	} ctx_t;

endpackage

/* src/tms_ram.sv */
// generic single write port, single read port ram with registered read
// no package dependency
module tms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read returns the old word on a same-address write
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/tms_cell.sv */
// one stage cell of the step chain: holds a transaction context and keeps
// the first error seen; depends on tms_pkg
module tms_cell import tms_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic            take,
	input  ctx_t            ctx_in,
	input  logic [ST_W-1:0] err_in,
	output logic            valid,
	output ctx_t            ctx
);

	logic valid_q;
	ctx_t ctx_q;
	ctx_t ctx_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load | (valid_q & ~take);
		end
	end

	// an earlier error wins over anything found in this stage
	always_comb begin
		ctx_nx = ctx_in;
		if (ctx_in.status == ST_OK) begin
			ctx_nx.status = err_in;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ctx_q <= ctx_nx;
		end
	end

	assign valid = valid_q;
	assign ctx   = ctx_q;

endmodule

/* src/turing_machine_step.sv */
// single-tape turing machine executor, top level
// uses tms_pkg, tms_cell (three-cell chain) and tms_ram (rule table, tape copies)
//
// Each transaction moves through a chain of three cells: the accept cycle reads
// the tape cell under the head, the first cell checks state and symbol and reads
// the rule table together with both neighbor cells, the second cell applies the
// write, move and next state, and the result lands in the output cell. A new
// transaction is accepted once the previous one has reached the output cell,
// so only one transaction is in the first and second cells at a time; the
// tape read, rule read and tape write chain sets that limit. The output cell
// may hold a stalled result while the next transaction is already in flight.
// After reset the tape is swept to blank, during which input is stalled;
// configuration writes are taken throughout.
module turing_machine_step import tms_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [ACT_W-1:0]     action,
	input  logic [STATE_W-1:0]   rule_state,
	input  logic [SYM_W-1:0]     rule_symbol,
	input  logic                 write_flag,
	input  logic [SYM_W-1:0]     write_symbol,
	input  logic [MOVE_W-1:0]    move,
	input  logic                 next_flag,
	input  logic [STATE_W-1:0]   next_state,
	input  logic [HEAD_W-1:0]    position,
	input  logic [SYM_W-1:0]     symbol,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ST_W-1:0]      status,
	output logic [HEAD_W-1:0]    head,
	output logic [STATE_W-1:0]   current_state,
	output logic [SYM_W-1:0]     read_symbol,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [NSTATES_W-1:0] num_states_q;
	logic [NSYMS_W-1:0]   num_symbols_q;
	logic [HEAD_W-1:0]    head_q;
	logic [STATE_W-1:0]   state_q;
	logic                 stopped_q;
	logic                 clearing_q;
	logic [HEAD_W-1:0]    clr_addr_q;

	logic in_fire, s2_fire, out_take;
	logic valid_s1, valid_s2;
	ctx_t ctx_acc, ctx_s1, ctx_s2_in, ctx_s2, ctx_s2_nx, ctx_out;
	logic [ST_W-1:0] err1, err2;

	logic [SYM_W-1:0]       sym1, cur_sym, rd_sym;
	logic [HEAD_W-1:0]      head_nx;
	logic [STATE_W-1:0]     state_nx;
	logic                   stop_nx;
	logic                   tape_wr;

	logic                   tape_we;
	logic [HEAD_W-1:0]      tape_waddr;
	logic [SYM_W-1:0]       tape_wdata;
	logic                   tape_re_a;
	logic [HEAD_W-1:0]      tape_raddr_a;
	logic [SYM_W-1:0]       tape_rdata_a, tape_rdata_b;

	logic                   rule_we;
	logic [RULE_ADDR_W-1:0] rule_waddr, rule_raddr;
	rule_t                  rule_wdata, rule_rd;

	assign in_stall = clearing_q | valid_s1 | valid_s2;
	assign in_fire  = in_valid & ~in_stall;
	assign out_take = out_valid & ~out_stall;
	assign s2_fire  = valid_s2 & (~out_valid | ~out_stall);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q  <= NUM_STATES_RST;
			num_symbols_q <= NUM_SYMBOLS_RST;
			head_q        <= '0;
			state_q       <= '0;
			stopped_q     <= 1'b1;
			clearing_q    <= 1'b1;
			clr_addr_q    <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_NUM_STATES: begin
						num_states_q <= cfg_data[NSTATES_W-1:0];
					end
					CFG_NUM_SYMBOLS: begin
						num_symbols_q <= cfg_data[NSYMS_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == HEAD_W'(TAPE_CELLS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (in_fire && action == ACT_START) begin
				head_q    <= position;
				state_q   <= rule_state;
				stopped_q <= 1'b0;
			end else if (s2_fire && ctx_s2.action == ACT_STEP) begin
				head_q    <= head_nx;
				state_q   <= state_nx;
				stopped_q <= stop_nx;
			end
		end
	end

	// accept: loads happen here, start has already moved the head
	always_comb begin
		ctx_acc        = '0;
		ctx_acc.action = action;
		ctx_acc.symbol = symbol;
		ctx_acc.fwd    = (action == ACT_LOAD_TAPE) && (position == head_q);
		ctx_acc.status = ST_OK;
	end

	tms_cell u_cell_s1 (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (in_fire),
		.take   (valid_s1),
		.ctx_in (ctx_acc),
		.err_in (ST_OK),
		.valid  (valid_s1),
		.ctx    (ctx_s1)
	);

	// first cell: symbol under head, state and symbol checks
	always_comb begin
		sym1 = ctx_s1.fwd ? ctx_s1.symbol : tape_rdata_a;
		if (ctx_s1.action == ACT_STEP) begin
			if (stopped_q) begin
				err1 = ST_STOPPED;
			end else if ({1'b0, state_q} >= num_states_q) begin
				err1 = ST_BAD_STATE;
			end else if ({1'b0, sym1} >= num_symbols_q) begin
				err1 = ST_BAD_HEAD;
			end else begin
				err1 = ST_OK;
			end
		end else begin
			err1 = stopped_q ? ST_STOPPED : ST_OK;
		end
	end

	always_comb begin
		ctx_s2_in     = ctx_s1;
		ctx_s2_in.sym = sym1;
	end

	tms_cell u_cell_s2 (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (valid_s1),
		.take   (s2_fire),
		.ctx_in (ctx_s2_in),
		.err_in (err1),
		.valid  (valid_s2),
		.ctx    (ctx_s2)
	);

	// second cell: write, move or halt, next state
	always_comb begin
		err2     = ST_OK;
		head_nx  = head_q;
		state_nx = state_q;
		tape_wr  = 1'b0;
		cur_sym  = ctx_s2.sym;
		rd_sym   = ctx_s2.sym;
		if (ctx_s2.action == ACT_STEP && ctx_s2.status == ST_OK) begin
			if (rule_rd.wflag) begin
				if ({1'b0, rule_rd.wsym} >= num_symbols_q) begin
					err2 = ST_BAD_WRITE;
				end else begin
					tape_wr = 1'b1;
					cur_sym = rule_rd.wsym;
				end
			end
			rd_sym = cur_sym;
			if (err2 == ST_OK) begin
				case (rule_rd.mv)
					MV_LEFT: begin
						if (head_q == '0) begin
							err2 = ST_EDGE;
						end else begin
							head_nx = head_q - 1'b1;
							rd_sym  = tape_rdata_a;
						end
					end
					MV_RIGHT: begin
						if (head_q == HEAD_W'(TAPE_CELLS - 1)) begin
							err2 = ST_EDGE;
						end else begin
							head_nx = head_q + 1'b1;
							rd_sym  = tape_rdata_b;
						end
					end
					MV_HALT: begin
						err2 = ST_HALTED;
					end
					default: begin
					end
				endcase
			end
			if (err2 == ST_OK && rule_rd.nflag) begin
				if ({1'b0, rule_rd.nstate} >= num_states_q) begin
					err2 = ST_BAD_NEXT;
				end else begin
					state_nx = rule_rd.nstate;
				end
			end
		end
		stop_nx = (err2 != ST_OK) || (ctx_s2.status != ST_OK);

		ctx_s2_nx        = ctx_s2;
		ctx_s2_nx.head   = head_nx;
		ctx_s2_nx.cstate = state_nx;
		ctx_s2_nx.sym    = rd_sym;
	end

	tms_cell u_cell_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (s2_fire),
		.take   (out_take),
		.ctx_in (ctx_s2_nx),
		.err_in (err2),
		.valid  (out_valid),
		.ctx    (ctx_out)
	);

	assign status        = ctx_out.status;
	assign head          = ctx_out.head;
	assign current_state = ctx_out.cstate;
	assign read_symbol   = ctx_out.sym;

	// tape: two copies written together, read at head-1 and head+1 in the first cell
	always_comb begin
		tape_we    = 1'b0;
		tape_waddr = head_q;
		tape_wdata = rule_rd.wsym;
		if (clearing_q) begin
			tape_we    = 1'b1;
			tape_waddr = clr_addr_q;
			tape_wdata = '0;
		end else if (in_fire && action == ACT_LOAD_TAPE) begin
			tape_we    = 1'b1;
			tape_waddr = position;
			tape_wdata = symbol;
		end else if (s2_fire && tape_wr) begin
			tape_we = 1'b1;
		end
	end

	assign tape_re_a = in_fire | valid_s1;

	always_comb begin
		if (valid_s1) begin
			tape_raddr_a = head_q - 1'b1;
		end else if (action inside {ACT_START, ACT_READ}) begin
			tape_raddr_a = position;
		end else begin
			tape_raddr_a = head_q;
		end
	end

	tms_ram #(.WIDTH(SYM_W), .DEPTH(TAPE_CELLS)) u_tape_a (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.re    (tape_re_a),
		.raddr (tape_raddr_a),
		.rdata (tape_rdata_a)
	);

	tms_ram #(.WIDTH(SYM_W), .DEPTH(TAPE_CELLS)) u_tape_b (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.re    (valid_s1),
		.raddr (head_q + 1'b1),
		.rdata (tape_rdata_b)
	);

	// rule table
	assign rule_we    = in_fire && action == ACT_LOAD_RULE;
	assign rule_waddr = {rule_state, rule_symbol};
	assign rule_raddr = {state_q, sym1};

	always_comb begin
		rule_wdata.wflag  = write_flag;
		rule_wdata.wsym   = write_symbol;
		rule_wdata.mv     = move;
		rule_wdata.nflag  = next_flag;
		rule_wdata.nstate = next_state;
	end

	tms_ram #(.WIDTH(RULE_W), .DEPTH(RULE_DEPTH)) u_rules (
		.clk   (clk),
		.we    (rule_we),
		.waddr (rule_waddr),
		.wdata (rule_wdata),
		.re    (valid_s1),
		.raddr (rule_raddr),
		.rdata (rule_rd)
	);

endmodule

/* src/tms_checker.sv */
// port-level checks for the turing machine step engine, bound to the top level
// uses tms_pkg
module tms_checker import tms_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [ST_W-1:0]    status,
	input logic [HEAD_W-1:0]  head,
	input logic [STATE_W-1:0] current_state,
	input logic [SYM_W-1:0]   read_symbol
);

	// one transaction at a time: input closes right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while a transaction is in flight");

	// every accept is followed by a valid result in the output cell after the first and second cells
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> ##3 out_valid)
		else $error("result missing three cycles after accept");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(head)
			&& $stable(current_state) && $stable(read_symbol)))
		else $error("stalled result changed");

	// right out of reset the tape sweep keeps the input closed
	a_sweep_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> in_stall)
		else $error("input open during tape sweep");

endmodule

bind turing_machine_step tms_checker u_tms_checker (.*);
